// ----- rtl/core/ppws_pkg.sv -----
// ppws_pkg: widths, register indexes, reset values and divider handshake types
// for the pulse period wind speed block; no dependencies
package ppws_pkg;

    localparam int TIMER_BITS_DEF = 32;
    localparam int PERIOD_W       = 32;
    localparam int SPEED_W        = 16;
    localparam int SCALE_W        = 20;
    localparam int VMAX_W         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    // scale_um * 1000 stays below 2^30
    localparam int DIVIDEND_W     = 30;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VMAX   = 3'd4;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = 20'd1000;
    localparam logic [PERIOD_W-1:0] DT_MIN_RST = 32'd1000;
    localparam logic [PERIOD_W-1:0] DT_MAX_RST = 32'd1000000;
    localparam logic [VMAX_W-1:0]   VMAX_RST   = 16'd50000;
    localparam logic [SPEED_W-1:0]  SPEED_CAP  = 16'hFFFF;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/ppws_if.sv -----
// ppws_if: request channels of the pulse period wind speed block
// depends on ppws_pkg for field widths
interface ppws_in_if;
    logic valid;
    logic ready;
    logic tick;
    logic edge_req;

    modport source (output valid, output tick, output edge_req, input ready);
    modport sink   (input valid, input tick, input edge_req, output ready);
endinterface

interface ppws_out_if;
    logic                           valid;
    logic                           ready;
    logic                           measuring;
    logic [ppws_pkg::PERIOD_W-1:0]  period_us;
    logic [ppws_pkg::SPEED_W-1:0]   speed_mm_s;

    modport source (output valid, output measuring, output period_us, output speed_mm_s,
                    input ready);
    modport sink   (input valid, input measuring, input period_us, input speed_mm_s,
                    output ready);
endinterface

// ----- rtl/core/ppws_div.sv -----
// ppws_div: bit-serial restoring divider, one quotient bit per cycle
// depends on ppws_pkg for the control and status structs
module ppws_div #(
    parameter int DIVIDEND_W = ppws_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = ppws_pkg::PERIOD_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ppws_pkg::div_ctrl_t     ctrl,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output ppws_pkg::div_stat_t     stat,
    output logic [DIVIDEND_W-1:0]   quotient
);
    import ppws_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            q_next   = {q_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !$past(ctrl.start)) |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

endmodule

// ----- rtl/core/pulse_period_wind_speed.sv -----
// pulse_period_wind_speed: cup anemometer speed from the pulse period
// depends on ppws_pkg, ppws_if (channels) and ppws_div (serial divider)
//
//  channel  dir  handshake             payload
//  sample   in   valid/ready           tick, edge_req
//  result   out  valid/ready           measuring, period_us, speed_mm_s
//  cfg      in   cfg_we (no wait)      cfg_idx, cfg_data
//
// an item with no period, a zero period or a period outside [dt_min_us,
// dt_max_us] goes through S_EDGE, S_EVAL and S_PUSH to the result register;
// others add S_DIV, one quotient bit per cycle over a 30-bit dividend
// rst_n clears the timer, measurement and control, and loads register defaults
// a finished result sits in the output register; the next request is taken
// while it waits, and a second result holds in the final state until taken
module pulse_period_wind_speed #(
    parameter int TIMER_BITS = ppws_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ppws_in_if.sink                           sample,
    ppws_out_if.source                        result,
    input  logic                              cfg_we,
    input  logic [ppws_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ppws_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ppws_pkg::*;

    // timer difference is widened so the saturation to 32 bits works at any width
    localparam int EXT_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EDGE = 5'b00010,
        S_EVAL = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUSH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;

    // configuration registers
    logic                  enable_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [PERIOD_W-1:0]   dt_min_reg;
    logic [PERIOD_W-1:0]   dt_max_reg;
    logic [VMAX_W-1:0]     vmax_reg;

    // measurement state
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [TIMER_BITS-1:0] last_reg, last_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic                  edge_seen_reg, edge_seen_next;
    logic                  have_period_reg, have_period_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;

    // latched request bit
    logic                  edge_reg, edge_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_meas_reg, out_meas_next;
    logic [PERIOD_W-1:0]   out_period_reg, out_period_next;
    logic [SPEED_W-1:0]    out_speed_reg, out_speed_next;

    logic                  accept;
    logic                  push_ok;
    logic [TIMER_BITS-1:0] diff;
    logic [EXT_W-1:0]      diff_ext;
    logic [PERIOD_W-1:0]   diff_sat;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVIDEND_W-1:0] quotient;
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign push_ok      = !out_valid_reg || result.ready;

    // elapsed time since the previous edge, wrapped, then clamped to 32 bits
    assign diff     = timer_reg - last_reg;
    assign diff_ext = EXT_W'(diff);
    assign diff_sat = (diff_ext > EXT_W'({PERIOD_W{1'b1}})) ? {PERIOD_W{1'b1}}
                                                             : diff_ext[PERIOD_W-1:0];

    // scale * 1000 as scale * 1024 - scale * 16 - scale * 8
    assign dividend = (DIVIDEND_W'(scale_reg) << 10) - (DIVIDEND_W'(scale_reg) << 4)
                    - (DIVIDEND_W'(scale_reg) << 3);

    ppws_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (PERIOD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (dividend),
        .divisor  (period_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next       = state_reg;
        timer_next       = timer_reg;
        last_next        = last_reg;
        period_next      = period_reg;
        edge_seen_next   = edge_seen_reg;
        have_period_next = have_period_reg;
        speed_next       = speed_reg;
        edge_next        = edge_reg;
        out_valid_next   = out_valid_reg;
        out_meas_next    = out_meas_reg;
        out_period_next  = out_period_reg;
        out_speed_next   = out_speed_reg;
        div_ctrl.start   = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // tick lands before the edge
                    timer_next = timer_reg + TIMER_BITS'(sample.tick);
                    edge_next  = sample.edge_req;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (enable_reg && edge_reg)
                begin
                    if (!edge_seen_reg)
                    begin
                        edge_seen_next = 1'b1;
                    end
                    else
                    begin
                        period_next      = diff_sat;
                        have_period_next = 1'b1;
                    end
                    last_next = timer_reg;
                end
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // upper bound before lower bound, so an inverted window reads zero above dt_max
                state_next = S_PUSH;
                if (!have_period_reg)
                begin
                    speed_next = '0;
                end
                else if (period_reg > dt_max_reg)
                begin
                    speed_next = '0;
                end
                else if (period_reg < dt_min_reg)
                begin
                    speed_next = vmax_reg;
                end
                else if (period_reg == '0)
                begin
                    speed_next = SPEED_CAP;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    speed_next = (|quotient[DIVIDEND_W-1:SPEED_W]) ? SPEED_CAP
                                                                    : quotient[SPEED_W-1:0];
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_meas_next   = edge_seen_reg;
                    out_period_next = edge_seen_reg ? period_reg : '0;
                    out_speed_next  = speed_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any write of the enable register restarts the measurement
        if (cfg_we && (cfg_idx == REG_ENABLE))
        begin
            period_next      = '0;
            edge_seen_next   = 1'b0;
            have_period_next = 1'b0;
            speed_next       = '0;
        end
    end

    // configuration writes, bits above each register's width dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            scale_reg  <= SCALE_RST;
            dt_min_reg <= DT_MIN_RST;
            dt_max_reg <= DT_MAX_RST;
            vmax_reg   <= VMAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_DT_MIN: dt_min_reg <= cfg_data[PERIOD_W-1:0];
                REG_DT_MAX: dt_max_reg <= cfg_data[PERIOD_W-1:0];
                REG_VMAX:   vmax_reg   <= cfg_data[VMAX_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            timer_reg       <= '0;
            last_reg        <= '0;
            period_reg      <= '0;
            edge_seen_reg   <= 1'b0;
            have_period_reg <= 1'b0;
            speed_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            timer_reg       <= timer_next;
            last_reg        <= last_next;
            period_reg      <= period_next;
            edge_seen_reg   <= edge_seen_next;
            have_period_reg <= have_period_next;
            speed_reg       <= speed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        edge_reg       <= edge_next;
        out_meas_reg   <= out_meas_next;
        out_period_reg <= out_period_next;
        out_speed_reg  <= out_speed_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.measuring  = out_meas_reg;
    assign result.period_us  = out_period_reg;
    assign result.speed_mm_s = out_speed_reg;

    a_period_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
        have_period_reg |-> edge_seen_reg)
        else $error("period flagged without a first edge");
    a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider running while block is idle");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result outside the divide state");
    a_quiet_when_idle_meas: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_meas_reg) |-> (out_period_reg == '0 && out_speed_reg == '0))
        else $error("result carries period or speed before any edge");
    a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && push_ok) |=> out_valid_reg)
        else $error("finished result not loaded into output register");

endmodule

// ----- sim/ppws_checker.sv -----
// ppws_checker: watches the sample, result and register-write ports of the
// pulse period wind speed block, predicts each reading and compares it
// depends on ppws_pkg and ppws_if
module ppws_checker #(
    parameter int TIMER_BITS = ppws_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ppws_in_if                                sample,
    ppws_out_if                               result,
    input  logic                              cfg_we,
    input  logic [ppws_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ppws_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    import ppws_pkg::*;

    localparam logic [63:0] MM_PER_M = 64'd1000;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic                measuring;
        logic [PERIOD_W-1:0] period_us;
        logic [SPEED_W-1:0]  speed_mm_s;
    } wind_reading_t;

    // register copies
    logic                  en_q;
    logic [SCALE_W-1:0]    scale_q;
    logic [PERIOD_W-1:0]   dt_min_q;
    logic [PERIOD_W-1:0]   dt_max_q;
    logic [VMAX_W-1:0]     vmax_q;

    // measurement state
    logic [TIMER_BITS-1:0] usec_now;
    logic [TIMER_BITS-1:0] last_edge_at;
    logic [PERIOD_W-1:0]   period_q;
    logic                  edge_seen_q;
    logic                  have_period_q;

    wind_reading_t         readings_due[$];
    wind_reading_t         got;
    wind_reading_t         want;

    function automatic void clear_measurement();
        period_q      = '0;
        edge_seen_q   = 1'b0;
        have_period_q = 1'b0;
    endfunction

    function automatic logic [SPEED_W-1:0] speed_for(input logic [PERIOD_W-1:0] p);
        logic [63:0] quot;
        if (!edge_seen_q || !have_period_q)
            return '0;
        // upper bound is tested first, so an inverted window reads zero above dt_max
        if (p > dt_max_q)
            return '0;
        if (p < dt_min_q)
            return vmax_q;
        if (p == '0)
            return SPEED_CAP;
        quot = (64'(scale_q) * MM_PER_M) / 64'(p);
        return (quot > 64'(SPEED_CAP)) ? SPEED_CAP : quot[SPEED_W-1:0];
    endfunction

    function automatic wind_reading_t step_sample(input logic tick, input logic edge_in);
        logic [TIMER_BITS-1:0] elapsed;
        wind_reading_t         r;
        if (tick)
            usec_now = usec_now + 1'b1;
        if (en_q && edge_in)
        begin
            if (!edge_seen_q)
            begin
                edge_seen_q = 1'b1;
            end
            else
            begin
                elapsed       = usec_now - last_edge_at;
                period_q      = (64'(elapsed) > 64'hFFFF_FFFF) ? '1 : PERIOD_W'(elapsed);
                have_period_q = 1'b1;
            end
            last_edge_at = usec_now;
        end
        r.measuring  = edge_seen_q;
        r.period_us  = edge_seen_q ? period_q : '0;
        r.speed_mm_s = speed_for(period_q);
        return r;
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        unique case (idx)
            REG_ENABLE:
            begin
                en_q = data[0];
                clear_measurement();
            end
            REG_SCALE:  scale_q  = data[SCALE_W-1:0];
            REG_DT_MIN: dt_min_q = data[PERIOD_W-1:0];
            REG_DT_MAX: dt_max_q = data[PERIOD_W-1:0];
            REG_VMAX:   vmax_q   = data[VMAX_W-1:0];
            default:    ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_q         = 1'b0;
            scale_q      = SCALE_RST;
            dt_min_q     = DT_MIN_RST;
            dt_max_q     = DT_MAX_RST;
            vmax_q       = VMAX_RST;
            usec_now     = '0;
            last_edge_at = '0;
            clear_measurement();
            readings_due.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{result.measuring, result.period_us, result.speed_mm_s};
                if (readings_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: reading with none due: measuring=%0b period=%0d speed=%0d",
                                 $time, got.measuring, got.period_us, got.speed_mm_s);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch: exp m=%0b p=%0d s=%0d, got m=%0b p=%0d s=%0d",
                                     $time, want.measuring, want.period_us, want.speed_mm_s,
                                     got.measuring, got.period_us, got.speed_mm_s);
                    end
                end
            end
            if (cfg_we)
                apply_write(cfg_idx, cfg_data);
            if (sample.valid && sample.ready)
                readings_due.push_back(step_sample(sample.tick, sample.edge_req));
            outstanding = readings_due.size();
        end
    end

endmodule

// ----- sim/pulse_period_wind_speed_tb.sv -----
// pulse_period_wind_speed_tb: drives ticks, pulse edges and register writes into
// the wind speed block and gives the verdict; checking is done by ppws_checker
// depends on ppws_pkg, ppws_if, pulse_period_wind_speed and ppws_checker
module pulse_period_wind_speed_tb;
    import ppws_pkg::*;

    localparam int TIMER_BITS    = TIMER_BITS_DEF;
    localparam int MAX_GAP       = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 105;
    // every request yields a reading, so once none is outstanding the block is idle
    localparam int IDLE_CYCLES   = 4;
    // about one divide plus the output register
    localparam int SETTLE_CYCLES = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    // when set, that side runs back to back with no idle cycles
    bit                    send_calm;
    bit                    take_calm;

    ppws_in_if  sample_ch ();
    ppws_out_if result_ch ();

    pulse_period_wind_speed #(
        .TIMER_BITS (TIMER_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    ppws_checker #(
        .TIMER_BITS (TIMER_BITS)
    ) reading_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 time unit clock, low half first
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stall before each reading, sometimes none at all
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        take_calm       = 1'b0;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            @(negedge clk);
        end
    end

    // one request: optional idle gap, then hold valid until taken
    // entered and left at a falling edge; valid stays high for a following request
    task automatic push_sample(input logic tick, input logic edge_in);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid    <= 1'b1;
        sample_ch.tick     <= tick;
        sample_ch.edge_req <= edge_in;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    // stop sending and wait until every reading is back and the block is quiet
    task automatic settle();
        sample_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // full register load from idle; junk goes into unused upper bits and,
    // when asked, to an index past the last register
    task automatic program_regs(input bit touch_enable, input bit en,
                                input logic [CFG_DATA_W-1:0] scale_word,
                                input logic [CFG_DATA_W-1:0] dt_min,
                                input logic [CFG_DATA_W-1:0] dt_max,
                                input logic [CFG_DATA_W-1:0] vmax_word,
                                input bit spare);
        settle();
        write_reg(REG_SCALE, scale_word);
        write_reg(REG_DT_MIN, dt_min);
        write_reg(REG_DT_MAX, dt_max);
        write_reg(REG_VMAX, vmax_word);
        if (spare)
            write_reg(REG_VMAX + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
        // enable write also clears the stored period and edge flag
        if (touch_enable)
            write_reg(REG_ENABLE, {31'($urandom), en});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] scale_w;
        logic [CFG_DATA_W-1:0] dt_min_w;
        logic [CFG_DATA_W-1:0] dt_max_w;
        int                    tick_pct;
        int                    edge_pct;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.tick     = 1'b0;
        sample_ch.edge_req = 1'b0;
        send_calm          = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----

        // reset defaults, still disabled: edges are ignored, timer runs
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b0);

        // enabled with default window: first edge only arms, short periods read vmax
        program_regs(1'b1, 1'b1, SCALE_RST, DT_MIN_RST, DT_MAX_RST, VMAX_RST, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);

        // scale of 1000000 with junk above bit 19, zero minimum so a zero period is valid,
        // period exactly at the maximum saturates, one past it reads zero
        program_regs(1'b1, 1'b1, 32'hFFF0_0000 | 32'd1000000, 32'd0, 32'd2,
                     32'hABCD_FFFF, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);

        // scale of one, window from 1 to the largest period, vmax of zero
        program_regs(1'b1, 1'b1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);

        // minimum above maximum, plus a write to an unused index
        program_regs(1'b1, 1'b1, 32'd500, 32'hFFFF_FFFF, 32'd3, 32'h5A5A_04D2, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);

        // disabling clears the measurement
        program_regs(1'b1, 1'b0, 32'd500, 32'd1, 32'd100, 32'd7, 1'b0);
        push_sample(1'b1, 1'b1);

        // ---- random part ----
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       scale_w = $urandom_range(1, 50);
                1:       scale_w = $urandom_range(51, 2000);
                2:       scale_w = $urandom_range(2001, 1000000);
                default: scale_w = ($urandom_range(0, 1) != 0) ? 32'd1 : 32'd1000000;
            endcase
            scale_w = scale_w | ($urandom & 32'hFFF0_0000);

            case ($urandom_range(0, 5))
                0:       dt_min_w = 32'd0;
                1:       dt_min_w = 32'hFFFF_FFFF;
                default: dt_min_w = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       dt_max_w = 32'hFFFF_FFFF;
                1:       dt_max_w = $urandom_range(1, 4);
                default: dt_max_w = $urandom_range(5, 60);
            endcase

            // first phase always writes the enable register; later ones sometimes keep the measurement
            program_regs((ph == 0) || ($urandom_range(0, 1) != 0),
                         $urandom_range(0, 7) != 0,
                         scale_w, dt_min_w, dt_max_w, $urandom,
                         $urandom_range(0, 2) == 0);

            send_calm = ($urandom_range(0, 3) == 0);
            tick_pct  = $urandom_range(40, 95);
            edge_pct  = $urandom_range(5, 40);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // in odd phases, hold off mid phase until the pipeline drains
                if (ph[0] && i == PHASE_ITEMS / 2)
                    settle();
                push_sample($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < edge_pct);
            end
        end

        // ---- wrap up ----
        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ppws_pkg.sv
rtl/core/ppws_if.sv
rtl/core/ppws_div.sv
rtl/core/pulse_period_wind_speed.sv
sim/ppws_checker.sv
sim/pulse_period_wind_speed_tb.sv
